// File: rtl/core/huffman_bit_packer_defines.svh
// ----------------------------------------------------------------------------
// Huffman bit packer assertion macros
// Shared property wrappers for the checker of the bit packer.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define HBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bit packer property failed");

// Next-cycle implication, disabled while reset is held
`define HBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bit packer property failed");

`endif

// File: rtl/core/hbp_pkg.sv
// ----------------------------------------------------------------------------
// Bit packer package
// Widths, request codes, sequencer states and the table write beat type.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;

    // Field widths of the item
    localparam int REQ_W    = 2;
    localparam int SYM_IN_W = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;

    // Derived widths
    localparam int SYM_W   = $clog2(NUM_SYMBOLS);
    localparam int CAP_LEN = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int ACC_W   = CAP_LEN + BYTE_BITS - 1;
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int PEND_W  = BYTE_BITS - 1;
    localparam int CNT_W   = $clog2(BYTE_BITS);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_tbl_wr;

endpackage

// File: rtl/core/hbp_code_table.sv
// ----------------------------------------------------------------------------
// Bit packer code table
// Length and code memories with one valid flag per entry; registered read.
// ----------------------------------------------------------------------------
module hbp_code_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hbp_pkg::t_tbl_wr            i_wr,
    input  logic [hbp_pkg::SYM_W-1:0]   i_rd_addr,
    output logic [hbp_pkg::LEN_W-1:0]   o_rd_len,
    output logic [hbp_pkg::CODE_W-1:0]  o_rd_bits
);
    import hbp_pkg::*;

    logic [LEN_W-1:0]       r_len_mem  [NUM_SYMBOLS];
    logic [CODE_W-1:0]      r_bits_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_valid;
    logic                   r_rd_vld;
    logic [LEN_W-1:0]       r_rd_len;
    logic [CODE_W-1:0]      r_rd_bits;

    // Track written entries; an unwritten entry reads as length zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    // Write one entry, read one entry every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_len_mem[i_wr.addr]  <= i_wr.len;
            r_bits_mem[i_wr.addr] <= i_wr.bits;
        end
        r_rd_len  <= r_len_mem[i_rd_addr];
        r_rd_bits <= r_bits_mem[i_rd_addr];
    end

    assign o_rd_len  = r_rd_vld ? r_rd_len : '0;
    assign o_rd_bits = r_rd_bits;

endmodule

// File: rtl/core/hbp_byte_shifter.sv
// ----------------------------------------------------------------------------
// Bit packer byte shifter
// Shared right shifter that picks one byte out of the bit accumulator.
// ----------------------------------------------------------------------------
module hbp_byte_shifter (
    input  logic [hbp_pkg::ACC_W-1:0]     i_data,
    input  logic [hbp_pkg::TOT_W-1:0]     i_amt,
    output logic [hbp_pkg::BYTE_BITS-1:0] o_byte
);
    import hbp_pkg::*;

    logic [ACC_W-1:0] shifted;

    // Drop the bits below the byte and keep the low byte
    assign shifted = i_data >> i_amt;
    assign o_byte  = shifted[BYTE_BITS-1:0];

endmodule

// File: rtl/core/huffman_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman bit packer
// Code table plus bit buffer; packs variable-length codes into bytes, MSB first.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  command  | i_start, o_busy        | i_req_type, i_symbol, i_code_len,
//           |                        | i_code_bits
//  result   | o_valid (strobe)       | o_out_byte, o_last
//
//  A command beat is taken when i_start is high and o_busy is low.
//  Load: written at the accept edge, ready again in the next cycle.
//  Encode: n output bytes (n = 0..4), none for a symbol of length zero; the
//  table read, then one byte a cycle out of the shared byte shifter.
//  Flush: one padded byte with bits pending, otherwise no result.
//  Reset clears the sequencer, the bit buffer and the table valid flags; no
//  clearing pass. Each result beat is shown for one cycle and cannot stall.
// ----------------------------------------------------------------------------
module huffman_bit_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [hbp_pkg::REQ_W-1:0]     i_req_type,
    input  logic [hbp_pkg::SYM_IN_W-1:0]  i_symbol,
    input  logic [hbp_pkg::LEN_W-1:0]     i_code_len,
    input  logic [hbp_pkg::CODE_W-1:0]    i_code_bits,
    output logic                          o_valid,
    output logic [hbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                          o_last
);
    import hbp_pkg::*;

    t_state                 r_state, n_state;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [TOT_W-1:0]       r_total, n_total;
    logic [PEND_W-1:0]      r_pend, n_pend;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_ovld, n_ovld;
    logic [BYTE_BITS-1:0]   r_obyte, n_obyte;
    logic                   r_olast, n_olast;

    logic                   accept;
    logic                   sym_ok;
    logic [LEN_W-1:0]       cap_len;
    logic [CODE_W-1:0]      code_mask;
    t_tbl_wr                tbl_wr;
    logic [LEN_W-1:0]       rd_len;
    logic [CODE_W-1:0]      rd_bits;
    logic [ACC_W-1:0]       sh_data;
    logic [TOT_W-1:0]       sh_amt;
    logic [BYTE_BITS-1:0]   sh_byte;
    logic                   have_byte;
    logic [TOT_W-1:0]       rem;
    logic [PEND_W-1:0]      pend_mask;

    assign accept = i_start && !o_busy;
    assign sym_ok = {1'b0, i_symbol} < (SYM_IN_W + 1)'(NUM_SYMBOLS);

    // Clamp the loaded length and drop stray code bits above it
    assign cap_len   = (i_code_len > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : i_code_len;
    assign code_mask = (cap_len >= LEN_W'(CODE_W)) ? '1
                     : ((CODE_W'(1) << cap_len) - CODE_W'(1));

    always_comb begin
        tbl_wr.en   = accept && (i_req_type == REQ_LOAD) && sym_ok;
        tbl_wr.addr = i_symbol[SYM_W-1:0];
        tbl_wr.len  = cap_len;
        tbl_wr.bits = i_code_bits & code_mask;
    end

    hbp_code_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (i_symbol[SYM_W-1:0]),
        .o_rd_len  (rd_len),
        .o_rd_bits (rd_bits)
    );

    // Bits left after this step's byte, and the mask for the leftover buffer
    assign have_byte = r_total >= TOT_W'(BYTE_BITS);
    assign rem       = have_byte ? (r_total - TOT_W'(BYTE_BITS)) : r_total;
    assign pend_mask = (PEND_W'(1) << rem[CNT_W-1:0]) - PEND_W'(1);

    // Feed the shared shifter: accumulator while emitting, padded buffer on flush
    always_comb begin
        if (r_state == ST_FLUSH) begin
            sh_data = ACC_W'({r_pend, {BYTE_BITS{1'b0}}});
            sh_amt  = TOT_W'(r_cnt);
        end else begin
            sh_data = r_acc;
            sh_amt  = rem;
        end
    end

    hbp_byte_shifter u_shifter (
        .i_data (sh_data),
        .i_amt  (sh_amt),
        .o_byte (sh_byte)
    );

    // Sequencer: next state, buffer update and result beat
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_total = r_total;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_ovld  = 1'b0;
        n_obyte = r_obyte;
        n_olast = r_olast;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ENCODE: begin
                            if (sym_ok) begin
                                n_state = ST_FETCH;
                            end
                        end
                        REQ_FLUSH: begin
                            if (r_cnt != '0) begin
                                n_state = ST_FLUSH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // Append the code below the pending bits
                if (rd_len == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_acc   = (ACC_W'(r_pend) << rd_len) | ACC_W'(rd_bits);
                    n_total = TOT_W'(r_cnt) + TOT_W'(rd_len);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Emit one full byte a cycle, keep the remainder when done
                if (have_byte) begin
                    n_ovld  = 1'b1;
                    n_obyte = sh_byte;
                    n_olast = rem < TOT_W'(BYTE_BITS);
                end
                n_total = rem;
                if (rem < TOT_W'(BYTE_BITS)) begin
                    n_pend  = r_acc[PEND_W-1:0] & pend_mask;
                    n_cnt   = rem[CNT_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                n_ovld  = 1'b1;
                n_obyte = sh_byte;
                n_olast = 1'b1;
                n_pend  = '0;
                n_cnt   = '0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_total <= n_total;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_busy     = r_state != ST_IDLE;
    assign o_valid    = r_ovld;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

endmodule

// File: rtl/core/hbp_checker.sv
// ----------------------------------------------------------------------------
// Bit packer port checker
// Watches the top level ports for result framing and load behaviour.
// ----------------------------------------------------------------------------
`include "huffman_bit_packer_defines.svh"

module hbp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_start,
    input logic                      o_busy,
    input logic [hbp_pkg::REQ_W-1:0] i_req_type,
    input logic                      o_valid,
    input logic                      o_last
);
    import hbp_pkg::*;

    logic load_beat;

    assign load_beat = i_start && !o_busy && (i_req_type == REQ_LOAD);

    // A load gives no result and leaves the block ready
    `HBP_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, load_beat, !o_valid && !o_busy)
    // Bytes of one item come in an unbroken run
    `HBP_ASSERT_NEXT(a_run_unbroken, i_clk, i_rst_n, o_valid && !o_last, o_valid)
    // Nothing follows directly after the closing byte
    `HBP_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    // More bytes pending means the block is still busy
    `HBP_ASSERT_NOW(a_busy_mid_run, i_clk, i_rst_n, o_valid && !o_last, o_busy)

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (.*);
